### src/rol_pkg.sv
// Shared types and constants for the reclaim order list.
`default_nettype none

package rol_pkg;

  localparam int ROL_ENTRIES = 128;

  typedef enum logic [2:0] {
    REQ_PLAIN   = 3'd0,
    REQ_MAPPED  = 3'd1,
    REQ_REQUEUE = 3'd2,
    REQ_UNREG   = 3'd3,
    REQ_POP     = 3'd4
  } rol_req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOTHING  = 3'd4
  } rol_status_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] page_va;
    logic [46:0] user_addr;
    logic [51:0] root_table_addr;
    logic [3:0]  reclaim_order;
  } rol_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] popped_page;
    logic [46:0] popped_user_addr;
    logic [51:0] popped_root_addr;
  } rol_out_t;

  typedef struct packed {
    logic [63:0] page;
    logic [46:0] user;
    logic [51:0] root;
  } rol_slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_WR,
    S_POP_WR,
    S_WALK,
    S_REL
  } rol_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WALK_INIT,
    OP_INS_COMMIT,
    OP_POP_COMMIT,
    OP_WALK_STEP,
    OP_UNLINK,
    OP_RELEASE
  } rol_op_t;

  typedef enum logic [1:0] {
    RD_FREE,
    RD_OLDEST,
    RD_NEXT
  } rol_rdsel_t;

  typedef struct packed {
    logic        ld_req;
    rol_rdsel_t  rd_sel;
    logic        data_we;
    rol_op_t     op;
    logic        finish;
    rol_status_t fin_status;
    logic        fin_pop;
  } rol_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       page_nz;
    logic       user_nz;
    logic       root_nz;
    logic       order_zero;
    logic       full;
    logic       empty;
    logic       hit;
    logic       walk_last;
    logic       pop_nz;
  } rol_stat_t;

endpackage

`default_nettype wire

### src/reclaim_order_list.sv
// Top level of the reclaim order list: controller, datapath and checks.
//
// Channel  Ports                    Handshake
// input    start, busy, in_data     word taken when start is high and busy is low
// result   out_valid, out_data      word shown for one cycle, marked by out_valid
//
// A rejected request, or an unregistration on an empty list, is answered from the
// dispatch state; a registration or a pop goes on from dispatch to its write state.
// An unregistration walks the list one entry per cycle through the link memory's
// single read port. The result is shown in the first cycle with busy low.
// Reset is synchronous; the list is empty at once, with no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module reclaim_order_list import rol_pkg::*; #(
  parameter int ENTRIES = ROL_ENTRIES
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire rol_in_t in_data,
  output logic         busy,
  output logic         out_valid,
  output rol_out_t     out_data
);

  rol_cmd_t  cmd;
  rol_stat_t stat;

  rol_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rol_datapath #(.ENTRIES(ENTRIES)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result shown without work in progress");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.popped_page == '0 && out_data.popped_user_addr == '0 &&
      out_data.popped_root_addr == '0)
    else $error("popped fields non-zero on an unsuccessful result");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.data_we |-> !stat.full)
    else $error("slot written while the pool is full");

endmodule

`default_nettype wire

### src/rol_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module rol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/rol_ctrl.sv
// Controller state machine sequencing each request of the reclaim order list.
`default_nettype none

module rol_ctrl import rol_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire rol_stat_t stat,
  output rol_cmd_t       cmd,
  output logic           busy
);

  rol_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.ld_req     = 1'b0;
    cmd.rd_sel     = RD_FREE;
    cmd.data_we    = 1'b0;
    cmd.op         = OP_NONE;
    cmd.finish     = 1'b0;
    cmd.fin_status = ST_OK;
    cmd.fin_pop    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        case (stat.req_type)
          REQ_PLAIN, REQ_MAPPED, REQ_REQUEUE: begin
            if ((stat.req_type == REQ_PLAIN && !stat.page_nz) ||
                (stat.req_type == REQ_MAPPED &&
                 !(stat.page_nz && stat.user_nz && stat.root_nz))) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_INVALID;
            end else if (stat.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.rd_sel  = RD_FREE;
              cmd.data_we = 1'b1;
              state_nxt   = S_INS_WR;
            end
          end
          REQ_UNREG: begin
            if (!stat.page_nz) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_INVALID;
            end else if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_NOTFOUND;
            end else begin
              cmd.rd_sel = RD_OLDEST;
              cmd.op     = OP_WALK_INIT;
              state_nxt  = S_WALK;
            end
          end
          REQ_POP: begin
            if (!stat.order_zero || stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_NOTHING;
            end else begin
              cmd.rd_sel = RD_OLDEST;
              state_nxt  = S_POP_WR;
            end
          end
          default: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_INVALID;
          end
        endcase
      end
      S_INS_WR: begin
        cmd.op     = OP_INS_COMMIT;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_POP_WR: begin
        cmd.op         = OP_POP_COMMIT;
        cmd.finish     = 1'b1;
        cmd.fin_status = stat.pop_nz ? ST_OK : ST_NOTHING;
        cmd.fin_pop    = stat.pop_nz;
        state_nxt      = S_IDLE;
      end
      S_WALK: begin
        if (stat.hit) begin
          cmd.op    = OP_UNLINK;
          state_nxt = S_REL;
        end else if (stat.walk_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.op     = OP_WALK_STEP;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_REL: begin
        cmd.op     = OP_RELEASE;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### src/rol_datapath.sv
// Datapath of the reclaim order list: list pointers, slot and link memories, result register.
`default_nettype none

module rol_datapath import rol_pkg::*; #(
  parameter int ENTRIES = ROL_ENTRIES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rol_in_t  in_data,
  input  wire rol_cmd_t cmd,
  output rol_stat_t     stat,
  output logic          out_valid,
  output rol_out_t      out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $bits(rol_slot_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  rol_in_t        req_r;
  rol_in_t        req_in;
  logic [IW-1:0]  oldest_r, oldest_nxt;
  logic [IW-1:0]  newest_r, newest_nxt;
  logic [IW-1:0]  free_r, free_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  hwm_r, hwm_nxt;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic [IW-1:0]  prev_r, prev_nxt;
  logic [IW-1:0]  n_r, n_nxt;
  logic           out_valid_r;
  rol_out_t       out_data_r;

  logic [IW-1:0]  raddr;
  logic           link_we;
  logic [IW-1:0]  link_waddr, link_wdata, link_rdata;
  logic [SW-1:0]  slot_wbits, slot_rbits;
  rol_slot_t      slot_wdata, slot_rdata;
  logic           fresh;
  logic [IW-1:0]  ins_next;

  rol_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  rol_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (cmd.data_we),
    .waddr (free_r),
    .wdata (slot_wbits),
    .raddr (raddr),
    .rdata (slot_rbits)
  );

  assign slot_wdata.page = req_r.page_va;
  assign slot_wdata.user = req_r.user_addr;
  assign slot_wdata.root = req_r.root_table_addr;
  assign slot_wbits      = SW'(slot_wdata);
  assign slot_rdata      = rol_slot_t'(slot_rbits);

  // Slots at or above the fill mark have never been written; their link is the next slot.
  assign fresh    = (CW'(free_r) >= hwm_r);
  assign ins_next = fresh ? ((free_r == LAST_IDX) ? '0 : free_r + IW'(1)) : link_rdata;

  assign stat.req_type   = req_r.req_type;
  assign stat.page_nz    = |req_r.page_va;
  assign stat.user_nz    = |req_r.user_addr;
  assign stat.root_nz    = |req_r.root_table_addr;
  assign stat.order_zero = (req_r.reclaim_order == '0);
  assign stat.full       = (count_r == FULL_CNT);
  assign stat.empty      = (count_r == '0);
  assign stat.hit        = (slot_rdata.page == req_r.page_va);
  assign stat.walk_last  = ((CW'(n_r) + CW'(1)) == count_r);
  assign stat.pop_nz     = |slot_rdata.page;

  always_comb begin
    case (cmd.rd_sel)
      RD_FREE:   raddr = free_r;
      RD_OLDEST: raddr = oldest_r;
      RD_NEXT:   raddr = link_rdata;
      default:   raddr = free_r;
    endcase
  end

  always_comb begin
    req_in = in_data;
    if (in_data.req_type == REQ_PLAIN) begin
      req_in.user_addr       = '0;
      req_in.root_table_addr = '0;
    end
  end

  always_comb begin
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    hwm_nxt    = hwm_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    n_nxt      = n_r;
    link_we    = 1'b0;
    link_waddr = free_r;
    link_wdata = free_r;
    case (cmd.op)
      OP_WALK_INIT: begin
        cur_nxt  = oldest_r;
        prev_nxt = oldest_r;
        n_nxt    = '0;
      end
      OP_INS_COMMIT: begin
        if (count_r != '0) begin
          link_we    = 1'b1;
          link_waddr = newest_r;
          link_wdata = free_r;
        end else begin
          oldest_nxt = free_r;
        end
        newest_nxt = free_r;
        free_nxt   = ins_next;
        count_nxt  = count_r + CW'(1);
        if (fresh) begin
          hwm_nxt = hwm_r + CW'(1);
        end
      end
      OP_POP_COMMIT: begin
        link_we    = 1'b1;
        link_waddr = oldest_r;
        link_wdata = free_r;
        oldest_nxt = link_rdata;
        free_nxt   = oldest_r;
        count_nxt  = count_r - CW'(1);
      end
      OP_WALK_STEP: begin
        prev_nxt = cur_r;
        cur_nxt  = link_rdata;
        n_nxt    = n_r + IW'(1);
      end
      OP_UNLINK: begin
        if (n_r != '0) begin
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = link_rdata;
        end else begin
          oldest_nxt = link_rdata;
        end
        if (stat.walk_last) begin
          newest_nxt = prev_r;
        end
      end
      OP_RELEASE: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = free_r;
        free_nxt   = cur_r;
        count_nxt  = count_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      newest_r    <= '0;
      free_r      <= '0;
      count_r     <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    n_r    <= n_nxt;
    if (cmd.ld_req) begin
      req_r <= req_in;
    end
    if (cmd.finish) begin
      out_data_r.status <= cmd.fin_status;
      if (cmd.fin_pop) begin
        out_data_r.popped_page      <= slot_rdata.page;
        out_data_r.popped_user_addr <= slot_rdata.user;
        out_data_r.popped_root_addr <= slot_rdata.root;
      end else begin
        out_data_r.popped_page      <= '0;
        out_data_r.popped_user_addr <= '0;
        out_data_r.popped_root_addr <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
